[sv/scu_pkg.sv]
`default_nettype none

package scu_pkg;

  // Port and internal formats
  localparam int ANGLE_W            = 24;
  localparam int OUT_W              = 16;
  localparam int Q30_W              = 32;
  localparam int Q30_FRAC           = 30;
  localparam int ANGLE_FRAC_BITS_DEF = 20;
  localparam int OUT_FRAC_BITS_DEF   = 15;

  // Q2.30 constants
  localparam logic signed [Q30_W-1:0] ONE_Q30         = 32'sd1073741824;
  localparam logic signed [Q30_W-1:0] TWO_OVER_PI_Q30 = 32'sd683565276;
  localparam logic signed [Q30_W-1:0] HALF_PI_Q30     = 32'sd1686629713;
  localparam logic signed [Q30_W-1:0] SIN_C3          = -32'sd178956974;
  localparam logic signed [Q30_W-1:0] SIN_C5          = 32'sd8947845;
  localparam logic signed [Q30_W-1:0] SIN_C7          = -32'sd213044;
  localparam logic signed [Q30_W-1:0] COS_C2          = -32'sd536870912;
  localparam logic signed [Q30_W-1:0] COS_C4          = 32'sd44739246;
  localparam logic signed [Q30_W-1:0] COS_C6          = -32'sd1491309;

  // Quadrant, low two bits of the rounded angle * 2/pi
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  // Kernel result handed to the output stage
  typedef struct packed {
    quad_t                    quad;
    logic signed [Q30_W-1:0]  sine;
    logic signed [Q30_W-1:0]  cosine;
  } kern_res_t;

endpackage

`default_nettype wire

[sv/scu_kernel.sv]
`default_nettype none

module scu_kernel (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [scu_pkg::Q30_W-1:0] in_r,
  input  scu_pkg::quad_t                   in_quad,
  output logic                             out_valid,
  input  logic                             out_stall,
  output scu_pkg::kern_res_t               out_res
);
  import scu_pkg::*;

  localparam int NK  = 10;
  localparam int PRW = 2 * Q30_W;
  localparam logic signed [PRW-1:0] RND_HALF = PRW'(1) << (Q30_FRAC - 1);

  // Full-width signed product
  function automatic logic signed [PRW-1:0] mul_w(input logic signed [Q30_W-1:0] a,
                                                  input logic signed [Q30_W-1:0] b);
    return PRW'(a) * PRW'(b);
  endfunction

  // Round a Q4.60 product back to Q2.30, ties upward
  function automatic logic signed [Q30_W-1:0] rnd_q30(input logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] t;
    t = p + RND_HALF;
    return signed'(t[Q30_W+Q30_FRAC-1:Q30_FRAC]);
  endfunction

  logic [NK-1:0] vld_r;
  logic [NK:0]   en;

  logic signed [Q30_W-1:0] r_r   [0:7];
  quad_t                   quad_r[0:8];
  logic signed [Q30_W-1:0] x2_r  [1:5];
  logic signed [Q30_W-1:0] c_r   [7:8];

  logic signed [PRW-1:0]   prr_r;
  logic signed [PRW-1:0]   ps2_r, pc2_r, ps4_r, pc4_r, ps6_r, pc6_r, ps8_r;
  logic signed [Q30_W-1:0] t5_r, t4_r, t3_r, t2_r, t1_r;
  kern_res_t               res_r;

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NK] = ~out_stall;
    for (int k = NK - 1; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k+1];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NK; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Carried operands
  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_r[0]    <= in_r;
      quad_r[0] <= in_quad;
    end
    for (int k = 1; k < 8; k++) begin
      if (en[k]) r_r[k] <= r_r[k-1];
    end
    for (int k = 1; k < 9; k++) begin
      if (en[k]) quad_r[k] <= quad_r[k-1];
    end
  end

  // Horner chain, sine and cosine side by side
  always_ff @(posedge clk) begin
    // r squared
    if (en[0]) prr_r <= mul_w(in_r, in_r);
    if (en[1]) x2_r[1] <= rnd_q30(prr_r);
    for (int k = 2; k < 6; k++) begin
      if (en[k]) x2_r[k] <= x2_r[k-1];
    end
    // innermost terms
    if (en[2]) begin
      ps2_r <= mul_w(x2_r[1], SIN_C7);
      pc2_r <= mul_w(x2_r[1], COS_C6);
    end
    if (en[3]) begin
      t5_r <= SIN_C5 + rnd_q30(ps2_r);
      t4_r <= COS_C4 + rnd_q30(pc2_r);
    end
    if (en[4]) begin
      ps4_r <= mul_w(x2_r[3], t5_r);
      pc4_r <= mul_w(x2_r[3], t4_r);
    end
    if (en[5]) begin
      t3_r <= SIN_C3 + rnd_q30(ps4_r);
      t2_r <= COS_C2 + rnd_q30(pc4_r);
    end
    if (en[6]) begin
      ps6_r <= mul_w(x2_r[5], t3_r);
      pc6_r <= mul_w(x2_r[5], t2_r);
    end
    if (en[7]) begin
      t1_r   <= ONE_Q30 + rnd_q30(ps6_r);
      c_r[7] <= ONE_Q30 + rnd_q30(pc6_r);
    end
    if (en[8]) c_r[8] <= c_r[7];
    // odd kernel times r
    if (en[8]) ps8_r <= mul_w(r_r[7], t1_r);
    if (en[9]) begin
      res_r.sine   <= rnd_q30(ps8_r);
      res_r.cosine <= c_r[8];
      res_r.quad   <= quad_r[8];
    end
  end

  assign in_stall  = ~en[0];
  assign out_valid = vld_r[NK-1];
  assign out_res   = res_r;

endmodule

`default_nettype wire

[sv/sine_cosine_unit.sv]
// sine_cosine_unit: sine and cosine of a fixed-point angle.
//
// Input channel: in_valid / in_stall carry one word, in_angle, a signed
// radian angle with ANGLE_FRAC_BITS fraction bits. Output channel:
// out_valid / out_stall carry one word per input, out_sine and out_cosine,
// signed with OUT_FRAC_BITS fraction bits, saturated to the 16-bit range.
// A word is taken at a clock edge where valid is high and stall is low.
//
// The path from an accepted input word to out_valid runs through three
// range-reduction stages, ten kernel stages (one 32x32 multiply or one
// rounding, with or without an add, per stage) and the output register.
// Throughput is one word per cycle while the receiver does not stall.
//
// Reset (rst_n low, synchronous) empties the pipeline; no output word is
// shown until a new input arrives. When the receiver stalls, the output
// holds and the stages behind it keep filling their empty slots;
// in_stall rises only once every stage holds a word.
`default_nettype none

module sine_cosine_unit #(
  parameter int ANGLE_FRAC_BITS = scu_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = scu_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [scu_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [scu_pkg::OUT_W-1:0]   out_sine,
  output logic signed [scu_pkg::OUT_W-1:0]   out_cosine
);
  import scu_pkg::*;

  // Range reduction widths
  localparam int PW  = ((ANGLE_W + Q30_W > ANGLE_FRAC_BITS + Q30_FRAC + 1) ?
                        ANGLE_W + Q30_W : ANGLE_FRAC_BITS + Q30_FRAC + 1) + 1;
  localparam int QSH = ANGLE_FRAC_BITS + Q30_FRAC;
  localparam int QW  = (ANGLE_W - ANGLE_FRAC_BITS + 3 > 3) ?
                       ANGLE_W - ANGLE_FRAC_BITS + 3 : 3;
  localparam int ASH = Q30_FRAC - ANGLE_FRAC_BITS;
  localparam int RW  = ((ANGLE_W + ASH + 1 > QW + Q30_W) ?
                        ANGLE_W + ASH + 1 : QW + Q30_W) + 1;
  localparam logic signed [PW-1:0] Q_HALF = PW'(1) << (QSH - 1);

  // Output rounding and saturation
  localparam int OSH = Q30_FRAC - OUT_FRAC_BITS;
  localparam int VW  = Q30_W + 2;
  localparam logic signed [VW-1:0] OUT_HALF = (VW'(1) << OSH) >>> 1;
  localparam logic signed [VW-1:0] OUT_MAX  = (VW'(1) << (OUT_W - 1)) - VW'(1);
  localparam logic signed [VW-1:0] OUT_MIN  = -(VW'(1) << (OUT_W - 1));

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Q30_W:0] v);
    logic signed [VW-1:0] t;
    t = (VW'(v) + OUT_HALF) >>> OSH;
    if (t > OUT_MAX) t = OUT_MAX;
    if (t < OUT_MIN) t = OUT_MIN;
    return signed'(t[OUT_W-1:0]);
  endfunction

  logic [2:0] vld_r;
  logic       en1, en2, en3, en_out;

  logic signed [PW-1:0]      p_r;
  logic signed [ANGLE_W-1:0] a1_r, a2_r;
  logic signed [QW-1:0]      q_r;
  logic signed [Q30_W-1:0]   r_r;
  quad_t                     quad_r;
  logic signed [PW-1:0]      qs;
  logic signed [RW-1:0]      rw;

  logic      k_valid, k_stall, k_in_stall;
  kern_res_t k_res;

  logic signed [Q30_W:0]   sel_s, sel_c;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_sine_r, out_cosine_r;

  // Stage enables
  assign en_out  = ~out_valid_r | ~out_stall;
  assign k_stall = ~en_out;
  assign en3     = ~vld_r[2] | ~k_in_stall;
  assign en2     = ~vld_r[1] | en3;
  assign en1     = ~vld_r[0] | en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    vld_r[0]    <= in_valid;
      if (en2)    vld_r[1]    <= vld_r[0];
      if (en3)    vld_r[2]    <= vld_r[1];
      if (en_out) out_valid_r <= k_valid;
    end
  end

  // Quadrant and remainder arithmetic
  always_comb begin
    qs = (p_r + Q_HALF) >>> QSH;
    rw = (RW'(a2_r) <<< ASH) - RW'(q_r) * RW'(HALF_PI_Q30);
  end

  // Range reduction: angle * 2/pi, round to quadrant, subtract q * pi/2
  always_ff @(posedge clk) begin
    if (en1) begin
      p_r  <= PW'(in_angle) * PW'(TWO_OVER_PI_Q30);
      a1_r <= in_angle;
    end
    if (en2) begin
      q_r  <= qs[QW-1:0];
      a2_r <= a1_r;
    end
    if (en3) begin
      r_r    <= rw[Q30_W-1:0];
      quad_r <= quad_t'(q_r[1:0]);
    end
  end

  scu_kernel u_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[2]),
    .in_stall  (k_in_stall),
    .in_r      (r_r),
    .in_quad   (quad_r),
    .out_valid (k_valid),
    .out_stall (k_stall),
    .out_res   (k_res)
  );

  // Quadrant select and sign
  always_comb begin
    case (k_res.quad)
      QUAD_0: begin
        sel_s = (Q30_W+1)'(k_res.sine);
        sel_c = (Q30_W+1)'(k_res.cosine);
      end
      QUAD_1: begin
        sel_s = (Q30_W+1)'(k_res.cosine);
        sel_c = -(Q30_W+1)'(k_res.sine);
      end
      QUAD_2: begin
        sel_s = -(Q30_W+1)'(k_res.sine);
        sel_c = -(Q30_W+1)'(k_res.cosine);
      end
      QUAD_3: begin
        sel_s = -(Q30_W+1)'(k_res.cosine);
        sel_c = (Q30_W+1)'(k_res.sine);
      end
      default: begin
        sel_s = (Q30_W+1)'(k_res.sine);
        sel_c = (Q30_W+1)'(k_res.cosine);
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_sine_r   <= sat_out(sel_s);
      out_cosine_r <= sat_out(sel_c);
    end
  end

  assign in_stall   = ~en1;
  assign out_valid  = out_valid_r;
  assign out_sine   = out_sine_r;
  assign out_cosine = out_cosine_r;

endmodule

`default_nettype wire

[sv/scu_checker.sv]
`default_nettype none

module scu_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [scu_pkg::OUT_W-1:0] out_sine,
  input logic signed [scu_pkg::OUT_W-1:0] out_cosine
);

  // A stalled output word stays up
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its value
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sine) && $stable(out_cosine))
    else $error("output word changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Input backpressure only comes from a stalled, full output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind sine_cosine_unit scu_checker u_scu_checker (.*);

`default_nettype wire

[bench/tb_sine_cosine_unit.sv]
`timescale 1ns / 1ps

module tb_sine_cosine_unit;

  localparam int ANG_W    = scu_pkg::ANGLE_W;
  localparam int RES_W    = scu_pkg::OUT_W;
  localparam int ANG_FRAC = scu_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int RES_FRAC = scu_pkg::OUT_FRAC_BITS_DEF;

  // Q2.30 fixed-point constants of the range reduction and the kernels
  localparam longint FX_ONE         = 64'sd1073741824;
  localparam longint FX_TWO_OVER_PI = 64'sd683565276;
  localparam longint FX_HALF_PI     = 64'sd1686629713;
  localparam longint FX_S3          = -64'sd178956974;
  localparam longint FX_S5          = 64'sd8947845;
  localparam longint FX_S7          = -64'sd213044;
  localparam longint FX_C2          = -64'sd536870912;
  localparam longint FX_C4          = 64'sd44739246;
  localparam longint FX_C6          = -64'sd1491309;
  localparam longint RES_MAX        = 64'sd32767;
  localparam longint RES_MIN        = -64'sd32768;

  localparam int DIRECTED_WORDS = 25;
  localparam int RANDOM_WORDS   = 1625;
  localparam int IDLE_LIMIT     = 2000;
  localparam int LOG_CAP        = 100;
  localparam int TAIL_CYCLES    = 40;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    bit                      drain_first;
  } feed_word_t;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic signed [RES_W-1:0] sine;
    logic signed [RES_W-1:0] cosine;
  } trig_word_t;

  // receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_RUNS
  } rx_pattern_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic signed [ANG_W-1:0] in_angle   = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic signed [RES_W-1:0] out_sine;
  logic signed [RES_W-1:0] out_cosine;

  feed_word_t  angle_feed[$];
  trig_word_t  trig_due[$];
  int          mismatches  = 0;
  int          words_in    = 0;
  int          feed_total  = 0;
  int          idle_cycles = 0;
  int          burst_left  = 1;
  int          gap_left    = 0;
  int          mode_left   = 0;
  int          run_left    = 0;
  bit          run_high    = 1'b0;
  rx_pattern_t rx_mode     = RX_FREE;

  sine_cosine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_angle   (in_angle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sine   (out_sine),
    .out_cosine (out_cosine)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round to nearest by 2^s, ties upward; >>> on a signed value floors
  function automatic longint round_sh(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_sh(a * b, 30);
  endfunction

  function automatic logic signed [RES_W-1:0] to_result(longint v);
    longint o;
    o = round_sh(v, 30 - RES_FRAC);
    if (o > RES_MAX) o = RES_MAX;
    if (o < RES_MIN) o = RES_MIN;
    return o[RES_W-1:0];
  endfunction

  // sine and cosine of one angle word
  function automatic trig_word_t trig_of(logic signed [ANG_W-1:0] ang);
    longint     a, quad_n, rem, x2, t, s, c, so, co;
    trig_word_t res;
    a      = longint'(ang);
    quad_n = round_sh(a * FX_TWO_OVER_PI, ANG_FRAC + 30);
    rem    = a * (longint'(1) <<< (30 - ANG_FRAC)) - quad_n * FX_HALF_PI;
    x2     = fx_mul(rem, rem);

    // odd kernel, order seven
    t = FX_S7;
    t = FX_S5 + fx_mul(x2, t);
    t = FX_S3 + fx_mul(x2, t);
    t = FX_ONE + fx_mul(x2, t);
    s = fx_mul(rem, t);

    // even kernel, order six
    t = FX_C6;
    t = FX_C4 + fx_mul(x2, t);
    t = FX_C2 + fx_mul(x2, t);
    c = FX_ONE + fx_mul(x2, t);

    case (scu_pkg::quad_t'(quad_n[1:0]))
      scu_pkg::QUAD_0: begin so = s;  co = c;  end
      scu_pkg::QUAD_1: begin so = c;  co = -s; end
      scu_pkg::QUAD_2: begin so = -s; co = -c; end
      default:         begin so = -c; co = s;  end
    endcase

    res.angle  = ang;
    res.sine   = to_result(so);
    res.cosine = to_result(co);
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    // keep the log short when everything goes wrong
    if (mismatches < LOG_CAP) $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  // sender: bursts and gaps, holds a word while stalled
  always @(posedge clk) begin : drive
    feed_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        trig_due.push_back(trig_of(in_angle));
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (angle_feed.size() == 0) begin
          in_valid <= 1'b0;
        end else if (angle_feed[0].drain_first && trig_due.size() != 0) begin
          // wait for the pipe to empty
          in_valid <= 1'b0;
        end else begin
          nxt = angle_feed.pop_front();
          in_valid <= 1'b1;
          in_angle <= nxt.angle;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_pattern_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
        default: begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 24);
            run_high = !run_high;
          end else begin
            run_left--;
          end
          out_stall <= run_high;
        end
      endcase
    end
  end

  // result check against the oldest expected word
  always @(posedge clk) begin : monitor
    trig_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (trig_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word sine=%0d cosine=%0d", out_sine, out_cosine));
      end else begin
        want = trig_due.pop_front();
        if (out_sine !== want.sine)
          flag_mismatch($sformatf("angle=%0d sine got %0d want %0d",
                                  want.angle, out_sine, want.sine));
        if (out_cosine !== want.cosine)
          flag_mismatch($sformatf("angle=%0d cosine got %0d want %0d",
                                  want.angle, out_cosine, want.cosine));
      end
    end
  end

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    feed_word_t w;
    real        bnd;
    real        scale;
    int         k;
    int         pick;
    int         base;

    scale = real'(1 << ANG_FRAC);

    // directed: extremes, zero, full-scale results
    w.drain_first = 1'b0;
    w.angle = '0;                                      angle_feed.push_back(w);
    w.angle = {1'b0, {(ANG_W-1){1'b1}}};               angle_feed.push_back(w);
    w.angle = {1'b1, {(ANG_W-1){1'b0}}};               angle_feed.push_back(w);
    w.angle = '1;                                      angle_feed.push_back(w);
    w.angle = ANG_W'($rtoi($floor(1.5707963267948966 * scale + 0.5)));
    angle_feed.push_back(w);

    // directed: both sides of every quadrant boundary, negative ones too
    for (k = -5; k <= 4; k++) begin
      bnd     = (real'(k) + 0.5) * 1.5707963267948966 * scale;
      w.angle = ANG_W'($rtoi($floor(bnd)));
      angle_feed.push_back(w);
      w.angle = ANG_W'($rtoi($floor(bnd)) + 1);
      angle_feed.push_back(w);
    end

    // random: mostly full range, some near zero, some near boundaries
    for (k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        w.angle = ANG_W'($urandom());
      end else if (pick < 17) begin
        w.angle = ANG_W'($signed($urandom_range(0, 8191)) - 4096);
      end else begin
        bnd     = (real'($signed($urandom_range(0, 9)) - 5) + 0.5) * 1.5707963267948966 * scale;
        base    = $rtoi($floor(bnd));
        w.angle = ANG_W'(base + $signed($urandom_range(0, 128)) - 64);
      end
      // first random word and a few others wait for an empty pipe
      w.drain_first = (k == 0) || ($urandom_range(0, 199) == 0);
      angle_feed.push_back(w);
    end
    feed_total = angle_feed.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (words_in != feed_total) @(posedge clk);
    while (trig_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/scu_pkg.sv
sv/scu_kernel.sv
sv/sine_cosine_unit.sv
sv/scu_checker.sv
bench/tb_sine_cosine_unit.sv
